>>> sv/gsb_pkg.sv
`timescale 1ns / 1ps
// gsb_pkg: shared types and constants of the stretch bound block
package gsb_pkg;

   localparam int PERIOD_W          = 20;
   localparam int TIME_W            = 24;
   localparam int Q_W               = 24;
   localparam int MAX_NODES_DEFAULT = 64;

   localparam logic [Q_W-1:0] ONE_Q16 = 24'h01_0000;
   localparam logic [Q_W-1:0] TOP_Q16 = 24'hFF_FFFF;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 20'd10000;
   localparam logic [Q_W-1:0]      CEILING_RESET = 24'h01_0000;

   // contact state codes
   localparam logic [1:0] KIND_SWING   = 2'd0;
   localparam logic [1:0] KIND_CONTACT = 2'd1;
   localparam logic [1:0] KIND_FREE    = 2'd2;
   localparam logic [1:0] KIND_SPARE   = 2'd3;

   // csr indexes
   localparam logic [1:0] CSR_NODE_PERIOD = 2'd0;
   localparam logic [1:0] CSR_MAX_SWING   = 2'd1;
   localparam logic [1:0] CSR_MAX_CONTACT = 2'd2;
   localparam logic [1:0] CSR_CEILING     = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_CHECK,
      ST_DIV,
      ST_APPLY,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      JOB_SWING,
      JOB_CONTACT,
      JOB_LEAD
   } job_type;

   typedef struct packed {
      logic    accept;   // take the input beat
      logic    prep;     // select operands of the job, form divisor
      logic    init;     // load divider or saturate quotient
      logic    step;     // one quotient bit
      logic    apply;    // lower the running bound
      logic    emit;     // load the result register
      job_type job;
   } cmd_type;

   typedef struct packed {
      logic job_en;      // current job has a live limit and a run
      logic sat;         // quotient exceeds the Q8.16 range
      logic last_foot;   // plan ends with this foot
      logic rsp_free;    // result register can take a beat
   } status_type;

endpackage

>>> sv/gsb_ctrl.sv
`timescale 1ns / 1ps
// gsb_ctrl: sequencer for node intake and the three bound divisions
module gsb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_last_node,
   output logic                req_stall,
   input  gsb_pkg::status_type status,
   output gsb_pkg::cmd_type    cmd
);

   localparam int CNT_W = $clog2(gsb_pkg::Q_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(gsb_pkg::Q_W - 1);

   gsb_pkg::state_type state_ff, state_in;
   gsb_pkg::job_type   job_ff, job_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gsb_pkg::ST_IDLE;
         job_ff   <= gsb_pkg::JOB_SWING;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         job_ff   <= job_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      logic              done;
      gsb_pkg::state_type after_job;
      gsb_pkg::job_type   next_job;

      state_in   = state_ff;
      job_in     = job_ff;
      count_in   = count_ff;
      cmd        = '0;
      cmd.job    = job_ff;
      req_stall  = (state_ff != gsb_pkg::ST_IDLE);

      done = (job_ff == gsb_pkg::JOB_LEAD);
      unique case (job_ff)
         gsb_pkg::JOB_SWING:   next_job = gsb_pkg::JOB_CONTACT;
         gsb_pkg::JOB_CONTACT: next_job = gsb_pkg::JOB_LEAD;
         default:              next_job = gsb_pkg::JOB_SWING;
      endcase
      if (!done) begin
         after_job = gsb_pkg::ST_PREP;
      end else if (status.last_foot) begin
         after_job = gsb_pkg::ST_EMIT;
      end else begin
         after_job = gsb_pkg::ST_IDLE;
      end

      unique case (state_ff)
         gsb_pkg::ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && req_last_node) begin
               state_in = gsb_pkg::ST_PREP;
               job_in   = gsb_pkg::JOB_SWING;
            end
         end
         gsb_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = gsb_pkg::ST_CHECK;
         end
         gsb_pkg::ST_CHECK: begin
            if (!status.job_en) begin
               state_in = after_job;
               job_in   = next_job;
            end else begin
               cmd.init = 1'b1;
               count_in = '0;
               state_in = status.sat ? gsb_pkg::ST_APPLY : gsb_pkg::ST_DIV;
            end
         end
         gsb_pkg::ST_DIV: begin
            cmd.step = 1'b1;
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_LAST) begin
               state_in = gsb_pkg::ST_APPLY;
            end
         end
         gsb_pkg::ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = after_job;
            job_in    = next_job;
         end
         gsb_pkg::ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = gsb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gsb_pkg::ST_IDLE;
         end
      endcase
   end

   // the divider runs exactly one quotient width of steps
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gsb_pkg::ST_DIV && count_ff == CNT_LAST) |=> state_ff == gsb_pkg::ST_APPLY)
      else $error("divider step count overrun");

   // the job sequence always closes on the leading run
   a_job_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gsb_pkg::ST_EMIT) |-> job_ff == gsb_pkg::JOB_SWING)
      else $error("emit before all jobs done");

endmodule

>>> sv/gsb_datapath.sv
`timescale 1ns / 1ps
// gsb_datapath: run tracking, csr file, bit-serial divider and result register
module gsb_datapath #(
   parameter int MAX_NODES = gsb_pkg::MAX_NODES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [1:0]                    req_foot_state,
   input  logic                          req_last_node,
   input  logic                          req_last_foot,
   input  logic                          req_measurement_present,
   input  logic                          req_contact_now,
   input  logic [gsb_pkg::TIME_W-1:0]    req_elapsed_us,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gsb_pkg::Q_W-1:0]       rsp_stretch_bound,
   input  logic                          csr_write_en,
   input  logic [1:0]                    csr_index,
   input  logic [gsb_pkg::TIME_W-1:0]    csr_wdata,
   input  gsb_pkg::cmd_type              cmd,
   output gsb_pkg::status_type           status
);

   localparam int NW  = $clog2(MAX_NODES + 1);
   localparam int DW  = gsb_pkg::PERIOD_W + NW;
   localparam int QW  = gsb_pkg::Q_W;
   localparam int TW  = gsb_pkg::TIME_W;
   localparam logic [NW-1:0] NODES_TOP = NW'(MAX_NODES);

   // csr file
   logic [gsb_pkg::PERIOD_W-1:0] period_ff;
   logic [TW-1:0]                max_swing_ff, max_contact_ff;
   logic [QW-1:0]                ceiling_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff      <= gsb_pkg::PERIOD_RESET;
         max_swing_ff   <= '0;
         max_contact_ff <= '0;
         ceiling_ff     <= gsb_pkg::CEILING_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            gsb_pkg::CSR_NODE_PERIOD: period_ff      <= csr_wdata[gsb_pkg::PERIOD_W-1:0];
            gsb_pkg::CSR_MAX_SWING:   max_swing_ff   <= csr_wdata;
            gsb_pkg::CSR_MAX_CONTACT: max_contact_ff <= csr_wdata;
            gsb_pkg::CSR_CEILING:     ceiling_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // run tracking state
   logic [NW-1:0] run_len_ff, lead_len_ff, long_contact_ff, long_swing_ff;
   logic [1:0]    run_kind_ff, lead_kind_ff;
   logic          in_lead_ff, first_node_ff, first_foot_ff;

   // operands of the pending jobs, latched on a foot's last node
   logic [NW-1:0] j_swing_ff, j_contact_ff, j_lead_ff;
   logic          j_lead_contact_ff, j_lead_en_ff, last_foot_ff;
   logic [TW-1:0] j_spent_ff;

   logic [1:0]    kind;
   logic          new_run, in_lead_n;
   logic [NW-1:0] run_base, run_len_n, lead_len_n, long_contact_n, long_swing_n;
   logic [1:0]    lead_kind_n;
   logic          lead_contact_n;

   always_comb begin
      kind      = (req_foot_state == gsb_pkg::KIND_SPARE) ? gsb_pkg::KIND_FREE
                                                          : req_foot_state;
      new_run   = first_node_ff || (kind != run_kind_ff);
      in_lead_n = in_lead_ff && !(new_run && !first_node_ff);
      run_base  = new_run ? '0 : run_len_ff;
      run_len_n = (run_base < NODES_TOP) ? run_base + 1'b1 : run_base;

      lead_len_n     = lead_len_ff;
      lead_kind_n    = lead_kind_ff;
      long_contact_n = long_contact_ff;
      long_swing_n   = long_swing_ff;
      if (in_lead_n) begin
         lead_len_n  = run_len_n;
         lead_kind_n = kind;
      end else if (kind == gsb_pkg::KIND_CONTACT) begin
         if (run_len_n > long_contact_ff) long_contact_n = run_len_n;
      end else if (kind == gsb_pkg::KIND_SWING) begin
         if (run_len_n > long_swing_ff) long_swing_n = run_len_n;
      end
      lead_contact_n = (lead_kind_n == gsb_pkg::KIND_CONTACT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_len_ff      <= '0;
         run_kind_ff     <= gsb_pkg::KIND_FREE;
         in_lead_ff      <= 1'b1;
         lead_len_ff     <= '0;
         lead_kind_ff    <= gsb_pkg::KIND_FREE;
         long_contact_ff <= '0;
         long_swing_ff   <= '0;
         first_node_ff   <= 1'b1;
         first_foot_ff   <= 1'b1;
         last_foot_ff    <= 1'b0;
      end else if (cmd.accept) begin
         if (req_last_node) begin
            // foot done: start the next foot fresh
            run_len_ff      <= '0;
            run_kind_ff     <= gsb_pkg::KIND_FREE;
            in_lead_ff      <= 1'b1;
            lead_len_ff     <= '0;
            lead_kind_ff    <= gsb_pkg::KIND_FREE;
            long_contact_ff <= '0;
            long_swing_ff   <= '0;
            first_node_ff   <= 1'b1;
            first_foot_ff   <= req_last_foot;
            last_foot_ff    <= req_last_foot;
         end else begin
            run_len_ff      <= run_len_n;
            run_kind_ff     <= kind;
            in_lead_ff      <= in_lead_n;
            lead_len_ff     <= lead_len_n;
            lead_kind_ff    <= lead_kind_n;
            long_contact_ff <= long_contact_n;
            long_swing_ff   <= long_swing_n;
            first_node_ff   <= 1'b0;
            first_foot_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && req_last_node) begin
         j_swing_ff        <= long_swing_n;
         j_contact_ff      <= long_contact_n;
         j_lead_ff         <= lead_len_n;
         j_lead_contact_ff <= lead_contact_n;
         j_lead_en_ff      <= (lead_len_n != '0) && (lead_kind_n != gsb_pkg::KIND_FREE);
         j_spent_ff        <= (req_measurement_present && (req_contact_now == lead_contact_n))
                              ? req_elapsed_us : '0;
      end
   end

   // job operand select and divisor product
   logic [TW-1:0]               limit_sel, spent_sel, rest_in, rest_ff;
   logic [NW-1:0]               nodes_sel;
   logic                        lead_ok;
   logic [gsb_pkg::PERIOD_W-1:0] dt_eff;
   logic [DW-1:0]               divisor_in, divisor_ff;
   logic                        job_en_ff;

   always_comb begin
      lead_ok = 1'b1;
      unique case (cmd.job)
         gsb_pkg::JOB_SWING: begin
            limit_sel = max_swing_ff;
            spent_sel = '0;
            nodes_sel = j_swing_ff;
         end
         gsb_pkg::JOB_CONTACT: begin
            limit_sel = max_contact_ff;
            spent_sel = '0;
            nodes_sel = j_contact_ff;
         end
         default: begin
            limit_sel = j_lead_contact_ff ? max_contact_ff : max_swing_ff;
            spent_sel = j_spent_ff;
            nodes_sel = j_lead_ff;
            lead_ok   = j_lead_en_ff;
         end
      endcase
      rest_in    = (limit_sel > spent_sel) ? limit_sel - spent_sel : '0;
      dt_eff     = (period_ff == '0) ? gsb_pkg::PERIOD_W'(1) : period_ff;
      divisor_in = DW'(dt_eff) * DW'(nodes_sel);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_en_ff <= 1'b0;
      end else if (cmd.prep) begin
         job_en_ff <= (limit_sel != '0) && (nodes_sel != '0) && lead_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.prep) begin
         rest_ff    <= rest_in;
         divisor_ff <= divisor_in;
      end
   end

   // restoring divider, one quotient bit a cycle: (rest << 16) / divisor
   logic [DW-1:0] rem_ff;
   logic [QW-1:0] nbits_ff, quot_ff;
   logic          sat;
   logic [DW:0]   trial;
   logic          qbit;

   always_comb begin
      sat   = (DW+8)'(rest_ff) >= {divisor_ff, 8'h00};
      trial = {rem_ff, nbits_ff[QW-1]};
      qbit  = trial >= {1'b0, divisor_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         rem_ff   <= DW'(rest_ff[TW-1:8]);
         nbits_ff <= {rest_ff[7:0], 16'h0000};
         quot_ff  <= sat ? gsb_pkg::TOP_Q16 : '0;
      end else if (cmd.step) begin
         rem_ff   <= qbit ? DW'(trial - {1'b0, divisor_ff}) : trial[DW-1:0];
         nbits_ff <= {nbits_ff[QW-2:0], 1'b0};
         quot_ff  <= {quot_ff[QW-2:0], qbit};
      end
   end

   // running bound and result register
   logic [QW-1:0] bound_ff, quot_floor, rsp_bound_ff;
   logic          rsp_valid_ff;

   assign quot_floor = (quot_ff < gsb_pkg::ONE_Q16) ? gsb_pkg::ONE_Q16 : quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bound_ff <= gsb_pkg::ONE_Q16;
      end else if (cmd.accept && first_node_ff && first_foot_ff) begin
         bound_ff <= (ceiling_ff < gsb_pkg::ONE_Q16) ? gsb_pkg::ONE_Q16 : ceiling_ff;
      end else if (cmd.apply && (quot_floor < bound_ff)) begin
         bound_ff <= quot_floor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_bound_ff <= bound_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_stretch_bound = rsp_bound_ff;

   assign status.job_en    = job_en_ff;
   assign status.sat       = sat;
   assign status.last_foot = last_foot_ff;
   assign status.rsp_free  = !rsp_valid_ff || !rsp_stall;

   a_bound_floor: assert property (@(posedge clock) disable iff (reset)
      bound_ff >= gsb_pkg::ONE_Q16)
      else $error("running bound below one");

   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (rem_ff < divisor_ff))
      else $error("divider remainder out of range");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while stalled");

   a_emit_plan: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> first_foot_ff)
      else $error("result emitted mid plan");

endmodule

>>> sv/gait_stretch_bound.sv
`timescale 1ns / 1ps
// gait_stretch_bound: top level of the gait time-grid stretch bound block
//
// usage
//   req channel: one beat per plan node, foot after foot; req_last_node marks
//   a foot's final node, req_last_foot on that node closes the plan
//   rsp channel: one beat per plan, the admissible stretch as unsigned Q8.16
//   csr port: write-only, index 0 node period, 1 max swing, 2 max contact,
//   3 stretch ceiling; write only while the block is idle
// intake and division order
//   ordinary nodes are taken back to back while the block is idle
//   a foot's last node holds the request side while three divisions run on
//   one shared restoring divider, each through an operand step, a check
//   step, quotient-bit steps and an update step, and on a plan's last foot
//   through the emit as well; a disabled limit ends after the check step, a
//   saturated quotient skips the quotient-bit steps
//   the emit waits after the last update until the result register is free,
//   and the result beat is valid in the cycle after it
// reset
//   synchronous, active high; csr registers go to their defaults, run state
//   clears, no result is pending
// stall
//   the result sits in an output register; the next plan's nodes are taken
//   while it waits, and a further result waits until the register drains
module gait_stretch_bound #(
   parameter int MAX_NODES = gsb_pkg::MAX_NODES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // node beats
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_foot_state,
   input  logic                          req_last_node,
   input  logic                          req_last_foot,
   input  logic                          req_measurement_present,
   input  logic                          req_contact_now,
   input  logic [gsb_pkg::TIME_W-1:0]    req_elapsed_us,
   // result beats
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gsb_pkg::Q_W-1:0]       rsp_stretch_bound,
   // csr writes
   input  logic                          csr_write_en,
   input  logic [1:0]                    csr_index,
   input  logic [gsb_pkg::TIME_W-1:0]    csr_wdata
);

   gsb_pkg::cmd_type    cmd;
   gsb_pkg::status_type status;

   // sequencer: intake, job order, divider steps, result hand-off
   gsb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_node (req_last_node),
      .req_stall     (req_stall),
      .status        (status),
      .cmd           (cmd)
   );

   // run lengths, limits, divider and bound registers
   gsb_datapath #(
      .MAX_NODES (MAX_NODES)
   ) u_datapath (
      .clock                   (clock),
      .reset                   (reset),
      .req_foot_state          (req_foot_state),
      .req_last_node           (req_last_node),
      .req_last_foot           (req_last_foot),
      .req_measurement_present (req_measurement_present),
      .req_contact_now         (req_contact_now),
      .req_elapsed_us          (req_elapsed_us),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_stretch_bound       (rsp_stretch_bound),
      .csr_write_en            (csr_write_en),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata),
      .cmd                     (cmd),
      .status                  (status)
   );

endmodule

>>> sim/gait_stretch_bound_test.sv
`timescale 1ns / 1ps
// gait_stretch_bound_test: self-checking testbench of the gait stretch bound block

class stretch_ledger;
   logic [gsb_pkg::PERIOD_W-1:0] node_period;
   logic [gsb_pkg::TIME_W-1:0]   max_swing;
   logic [gsb_pkg::TIME_W-1:0]   max_contact;
   logic [gsb_pkg::Q_W-1:0]      ceiling;
   int unsigned                  run_len;
   int unsigned                  lead_len;
   int unsigned                  longest_contact;
   int unsigned                  longest_swing;
   logic [1:0]                   run_kind;
   logic [1:0]                   lead_kind;
   bit                           in_lead;
   bit                           first_node;
   bit                           first_foot;
   logic [gsb_pkg::Q_W-1:0]      bound;
   logic [gsb_pkg::Q_W-1:0]      pending_bounds[$];
   int unsigned                  nodes_taken;
   int unsigned                  bounds_checked;
   int unsigned                  errors;

   function new();
      node_period = gsb_pkg::PERIOD_RESET;
      max_swing   = '0;
      max_contact = '0;
      ceiling     = gsb_pkg::CEILING_RESET;
      clear_foot();
      first_foot  = 1'b1;
      bound       = gsb_pkg::ONE_Q16;
   endfunction

   function void clear_foot();
      run_len         = 0;
      run_kind        = gsb_pkg::KIND_FREE;
      in_lead         = 1'b1;
      lead_len        = 0;
      lead_kind       = gsb_pkg::KIND_FREE;
      longest_contact = 0;
      longest_swing   = 0;
      first_node      = 1'b1;
   endfunction

   function void write_reg(input logic [1:0] index,
                           input logic [gsb_pkg::TIME_W-1:0] data);
      case (index)
         gsb_pkg::CSR_NODE_PERIOD: node_period = data[gsb_pkg::PERIOD_W-1:0];
         gsb_pkg::CSR_MAX_SWING:   max_swing   = data;
         gsb_pkg::CSR_MAX_CONTACT: max_contact = data;
         gsb_pkg::CSR_CEILING:     ceiling     = data;
         default: ;
      endcase
   endfunction

   // bound = min(bound, clamp((limit - spent) / (dt * nodes), 1, top)) in Q8.16
   function void lower_bound(input longint unsigned limit, spent, nodes);
      longint unsigned dt;
      longint unsigned rest;
      longint unsigned q;
      if (limit == 0 || nodes == 0) return;
      dt   = (node_period == '0) ? 64'd1 : 64'(node_period);
      rest = (limit > spent) ? limit - spent : 64'd0;
      q    = (rest << 16) / (dt * nodes);
      if (q > 64'(gsb_pkg::TOP_Q16)) q = 64'(gsb_pkg::TOP_Q16);
      if (q < 64'(gsb_pkg::ONE_Q16)) q = 64'(gsb_pkg::ONE_Q16);
      if (q < 64'(bound)) bound = q[gsb_pkg::Q_W-1:0];
   endfunction

   function void note_node(input logic [1:0] state, input bit last_node, last_foot, meas,
                           contact, input logic [gsb_pkg::TIME_W-1:0] elapsed);
      logic [1:0]                 kind;
      bit                         lead_contact;
      logic [gsb_pkg::TIME_W-1:0] limit;
      logic [gsb_pkg::TIME_W-1:0] spent;
      nodes_taken++;
      kind = (state == gsb_pkg::KIND_SPARE) ? gsb_pkg::KIND_FREE : state;
      if (first_foot && first_node)
         bound = (ceiling < gsb_pkg::ONE_Q16) ? gsb_pkg::ONE_Q16 : ceiling;
      if (first_node || kind != run_kind) begin
         if (!first_node) in_lead = 1'b0;
         run_kind = kind;
         run_len  = 0;
      end
      if (run_len < gsb_pkg::MAX_NODES_DEFAULT) run_len++;
      if (in_lead) begin
         lead_len  = run_len;
         lead_kind = run_kind;
      end else if (run_kind == gsb_pkg::KIND_CONTACT) begin
         if (run_len > longest_contact) longest_contact = run_len;
      end else if (run_kind == gsb_pkg::KIND_SWING) begin
         if (run_len > longest_swing) longest_swing = run_len;
      end
      first_node = 1'b0;
      if (!last_node) begin
         first_foot = 1'b0;
         return;
      end
      lower_bound(64'(max_swing), 64'd0, 64'(longest_swing));
      lower_bound(64'(max_contact), 64'd0, 64'(longest_contact));
      if (lead_len > 0 && lead_kind != gsb_pkg::KIND_FREE) begin
         lead_contact = (lead_kind == gsb_pkg::KIND_CONTACT);
         limit = lead_contact ? max_contact : max_swing;
         spent = (meas && (contact == lead_contact)) ? elapsed : '0;
         lower_bound(64'(limit), 64'(spent), 64'(lead_len));
      end
      clear_foot();
      if (!last_foot) begin
         first_foot = 1'b0;
         return;
      end
      pending_bounds.push_back(bound);
      first_foot = 1'b1;
   endfunction

   function void check_bound(input logic [gsb_pkg::Q_W-1:0] actual);
      logic [gsb_pkg::Q_W-1:0] wanted;
      if (pending_bounds.size() == 0) begin
         errors++;
         $display("%0t: stretch_bound beat with none expected, expected none, actual %h",
                  $time, actual);
         return;
      end
      wanted = pending_bounds.pop_front();
      bounds_checked++;
      if (actual !== wanted) begin
         errors++;
         $display("%0t: stretch_bound mismatch, expected %h, actual %h", $time, wanted, actual);
      end
   endfunction
endclass

module gait_stretch_bound_test;

   localparam int     GAP_MAX      = 12;
   // drain time for the divisions and the emit that a last node starts
   localparam int     DRAIN_CYCLES = 100;
   localparam int     HOLD_CYCLES  = 400;
   localparam int     PHASE_NODES  = 190;
   localparam int     PHASES       = 10;
   localparam longint TIMEOUT_NS   = 64'd20_000_000;

   logic                         clock                   = 1'b0;
   logic                         reset                   = 1'b1;
   logic                         req_valid               = 1'b0;
   logic                         req_stall;
   logic [1:0]                   req_foot_state          = gsb_pkg::KIND_SWING;
   logic                         req_last_node           = 1'b0;
   logic                         req_last_foot           = 1'b0;
   logic                         req_measurement_present = 1'b0;
   logic                         req_contact_now         = 1'b0;
   logic [gsb_pkg::TIME_W-1:0]   req_elapsed_us          = '0;
   logic                         rsp_valid;
   logic                         rsp_stall               = 1'b0;
   logic [gsb_pkg::Q_W-1:0]      rsp_stretch_bound;
   logic                         csr_write_en            = 1'b0;
   logic [1:0]                   csr_index               = gsb_pkg::CSR_NODE_PERIOD;
   logic [gsb_pkg::TIME_W-1:0]   csr_wdata               = '0;

   stretch_ledger sb;

   // burst modes: while set, that side inserts no random gaps
   bit          sender_eager   = 1'b0;
   bit          receiver_eager = 1'b0;
   // sender asks the sink for one long hold-off
   bit          hold_request   = 1'b0;
   int unsigned holds_done     = 0;
   int unsigned pauses_done    = 0;
   int unsigned settings_used  = 0;

   gait_stretch_bound dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_foot_state          (req_foot_state),
      .req_last_node           (req_last_node),
      .req_last_foot           (req_last_foot),
      .req_measurement_present (req_measurement_present),
      .req_contact_now         (req_contact_now),
      .req_elapsed_us          (req_elapsed_us),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_stretch_bound       (rsp_stretch_bound),
      .csr_write_en            (csr_write_en),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   always #5 clock = ~clock;

   // one csr write per cycle, mirrored into the ledger once it has landed
   task automatic write_reg(input logic [1:0] index, input logic [gsb_pkg::TIME_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= index;
      csr_wdata    <= data;
      @(posedge clock);
      sb.write_reg(index, data);
   endtask

   task automatic write_settings(input logic [gsb_pkg::TIME_W-1:0] period, swing, contact,
                                 ceil);
      write_reg(gsb_pkg::CSR_NODE_PERIOD, period);
      write_reg(gsb_pkg::CSR_MAX_SWING, swing);
      write_reg(gsb_pkg::CSR_MAX_CONTACT, contact);
      write_reg(gsb_pkg::CSR_CEILING, ceil);
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   // called at a clock edge; returns at the edge that took the beat
   task automatic send_node(input logic [1:0] state, input bit last_node, last_foot, meas,
                            contact, input logic [gsb_pkg::TIME_W-1:0] elapsed);
      int gap;
      if ($urandom_range(0, 63) == 0) sender_eager = !sender_eager;
      gap = sender_eager ? 0 : int'($urandom_range(0, GAP_MAX));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid               <= 1'b1;
      req_foot_state          <= state;
      req_last_node           <= last_node;
      req_last_foot           <= last_foot;
      req_measurement_present <= meas;
      req_contact_now         <= contact;
      req_elapsed_us          <= elapsed;
      do @(posedge clock); while (req_stall);
      sb.note_node(state, last_node, last_foot, meas, contact, elapsed);
   endtask

   // elapsed time spread around the current limits, plus the extremes
   function automatic logic [gsb_pkg::TIME_W-1:0] pick_elapsed();
      logic [gsb_pkg::TIME_W-1:0] hint;
      hint = (sb.max_swing > sb.max_contact) ? sb.max_swing : sb.max_contact;
      if (hint == '0) hint = 24'd1000000;
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return gsb_pkg::TIME_W'($urandom());
         default: return gsb_pkg::TIME_W'($urandom_range(0, 32'(hint)));
      endcase
   endfunction

   // a plan of well-formed feet: runs of random kind, last node and last foot marked
   task automatic send_plan(input int feet);
      int         f;
      int         r;
      int         i;
      int         runs;
      int         len;
      bit         last;
      logic [1:0] kind;
      for (f = 0; f < feet; f++) begin
         runs = int'($urandom_range(1, 4));
         for (r = 0; r < runs; r++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: kind = gsb_pkg::KIND_SWING;
               4, 5, 6, 7: kind = gsb_pkg::KIND_CONTACT;
               8:          kind = gsb_pkg::KIND_FREE;
               default:    kind = gsb_pkg::KIND_SPARE;
            endcase
            // now and then a run near or past the run length ceiling
            len = ($urandom_range(0, 39) == 0) ?
                  int'($urandom_range(gsb_pkg::MAX_NODES_DEFAULT - 2,
                                      gsb_pkg::MAX_NODES_DEFAULT + 12)) :
                  int'($urandom_range(1, 8));
            for (i = 0; i < len; i++) begin
               last = (r == runs - 1) && (i == len - 1);
               send_node(kind, last,
                         last ? (f == feet - 1) : ($urandom_range(0, 7) == 0),
                         last ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), pick_elapsed());
            end
         end
      end
   endtask

   // sender stops offering beats until every expected bound has come back
   task automatic wait_for_bounds();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending_bounds.size() != 0);
   endtask

   // block idle: no bound due, and enough cycles for a trailing division chain
   task automatic finish_phase();
      wait_for_bounds();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int          phase;
      int unsigned start;
      int unsigned period;
      int unsigned swing;
      int unsigned contact;
      int unsigned ceil;
      bit          held;
      bit          paused;
      sb     = new();
      held   = 1'b0;
      paused = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed plans with a wide ceiling so that every limit shows through
      write_settings(24'd10000, 24'd350000, 24'd600000, gsb_pkg::TOP_Q16);
      // contact lead, swing and contact runs after it, stray last_foot mid-foot,
      // measured contact matches the lead so elapsed time shortens its limit
      send_node(gsb_pkg::KIND_CONTACT, 1'b0, 1'b0, 1'b0, 1'b0, '0);
      send_node(gsb_pkg::KIND_CONTACT, 1'b0, 1'b0, 1'b0, 1'b0, '0);
      send_node(gsb_pkg::KIND_SWING, 1'b0, 1'b1, 1'b0, 1'b0, '0);
      send_node(gsb_pkg::KIND_SWING, 1'b0, 1'b0, 1'b0, 1'b0, '0);
      send_node(gsb_pkg::KIND_SWING, 1'b0, 1'b0, 1'b0, 1'b0, '0);
      send_node(gsb_pkg::KIND_CONTACT, 1'b0, 1'b0, 1'b0, 1'b0, '0);
      send_node(gsb_pkg::KIND_SWING, 1'b1, 1'b1, 1'b1, 1'b1, 24'd200000);
      // swing-only foot with elapsed time past the limit: bound drops to one
      send_node(gsb_pkg::KIND_SWING, 1'b0, 1'b0, 1'b0, 1'b0, '0);
      send_node(gsb_pkg::KIND_SWING, 1'b0, 1'b0, 1'b0, 1'b0, '0);
      send_node(gsb_pkg::KIND_SWING, 1'b1, 1'b0, 1'b1, 1'b0, '1);
      // undecided lead written with the spare code, then an undecided tail
      send_node(gsb_pkg::KIND_SPARE, 1'b0, 1'b0, 1'b0, 1'b0, '0);
      send_node(gsb_pkg::KIND_SPARE, 1'b0, 1'b0, 1'b0, 1'b0, '0);
      send_node(gsb_pkg::KIND_CONTACT, 1'b0, 1'b0, 1'b0, 1'b0, '0);
      send_node(gsb_pkg::KIND_FREE, 1'b1, 1'b1, 1'b1, 1'b1, 24'd5);
      // single-node plan, measurement from the other phase is ignored
      send_node(gsb_pkg::KIND_CONTACT, 1'b1, 1'b1, 1'b1, 1'b0, 24'h123456);
      // undecided one-node foot, then a swing lead with a matching swing measurement
      send_node(gsb_pkg::KIND_FREE, 1'b1, 1'b0, 1'b1, 1'b1, '1);
      send_node(gsb_pkg::KIND_SWING, 1'b0, 1'b0, 1'b0, 1'b0, '0);
      send_node(gsb_pkg::KIND_SWING, 1'b0, 1'b0, 1'b0, 1'b0, '0);
      send_node(gsb_pkg::KIND_CONTACT, 1'b1, 1'b1, 1'b1, 1'b0, 24'd50000);
      finish_phase();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: write_settings(24'd10000, 24'd400000, 24'd800000, 24'h08_0000);
            // zero period acts as one microsecond
            1: write_settings(24'd0, 24'd300, 24'd500, gsb_pkg::TOP_Q16);
            // quotients far above the Q8.16 range
            2: write_settings(24'd1, '1, '1, gsb_pkg::TOP_Q16);
            // long period, contact limit off, ceiling below one
            3: write_settings(24'd1000000, '1, 24'd0, 24'd0);
            4: write_settings(24'hF_FFFF, 24'd1, '1, 24'h00_FFFF);
            default: begin
               period  = $urandom_range(500, 20000);
               swing   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(period, period * 80);
               contact = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(period, period * 80);
               ceil    = ($urandom_range(0, 3) == 0) ? $urandom() :
                         $urandom_range(32'(gsb_pkg::ONE_Q16), 32'h0040_0000);
               write_settings(gsb_pkg::TIME_W'(period), gsb_pkg::TIME_W'(swing),
                              gsb_pkg::TIME_W'(contact), gsb_pkg::TIME_W'(ceil));
            end
         endcase
         start = sb.nodes_taken;
         while (sb.nodes_taken - start < PHASE_NODES) begin
            // sink holds off while plans keep coming, so the block backs up
            if (phase == 1 && !held && sb.nodes_taken - start > 30) begin
               hold_request = 1'b1;
               held         = 1'b1;
            end
            if (phase == 4 && !paused && sb.nodes_taken - start > 90) begin
               wait_for_bounds();
               paused = 1'b1;
               pauses_done++;
            end
            if ($urandom_range(0, 6) == 0) begin
               // noise: fields at random, markers included
               repeat ($urandom_range(1, 6))
                  send_node(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            1'($urandom_range(0, 1)), pick_elapsed());
            end else begin
               send_plan(int'($urandom_range(1, 3)));
            end
         end
         // close the open plan so the next settings start clean
         send_plan(int'($urandom_range(1, 3)));
         finish_phase();
      end

      $display("checked %0d stretch bounds from %0d node beats under %0d register settings",
               sb.bounds_checked, sb.nodes_taken, settings_used);
      $display("long result hold-offs: %0d, sender pauses to drain: %0d",
               holds_done, pauses_done + PHASES + 1);
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // result sink: random stall per beat, burst stretches, one long hold-off
   initial begin : result_sink
      int gap;
      wait (reset == 1'b0);
      forever begin
         if ($urandom_range(0, 63) == 0) receiver_eager = !receiver_eager;
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end
         gap = receiver_eager ? 0 : int'($urandom_range(0, GAP_MAX));
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_bound(rsp_stretch_bound);
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("%0t: run did not complete in time", $time);
      $display("== FAIL ==");
      $finish;
   end

endmodule
